[rtl/core/rcc_pkg.sv]
// shared types and constants for the rgb 3x3 convolution block
// no dependencies
package rcc_pkg;

   localparam int MAX_WIDTH_DEF      = 2048;
   localparam int COEF_FRAC_BITS_DEF = 8;

   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 3;
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 16;
   localparam int ROW_W     = HEIGHT_W + 1;
   localparam int TAPS      = 9;
   localparam int PIX_MAX   = 255;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOTTOM  = 3'd4;

   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;
   localparam logic [CSR_W-1:0]    COEF_TOP_RST     = 48'd0;
   localparam logic [CSR_W-1:0]    COEF_MID_RST     = 48'd16777216;
   localparam logic [CSR_W-1:0]    COEF_BOTTOM_RST  = 48'd0;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef logic [23:0] pixel_type;

   typedef struct packed {
      logic            emit;
      logic            frame_end;
      logic [TAPS-1:0] mask;
   } tag_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } result_type;

endpackage

[rtl/core/rcc_if.sv]
// word channels of the rgb 3x3 convolution block
// no dependencies
interface rcc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, op, red_in, green_in, blue_in, input ready);
   modport sink (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface rcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end;
   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

[rtl/core/rcc_front.sv]
// input position tracking: frame wrap, drain handling, tap masks, frame end
// depends on rcc_pkg
module rcc_front #(
   parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEF,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         req_valid,
   input  logic                         req_op,
   input  rcc_pkg::pixel_type           req_pix,
   input  logic [rcc_pkg::WIDTH_W-1:0]  frame_width,
   input  logic [rcc_pkg::HEIGHT_W-1:0] frame_height,
   output logic                         load,
   output logic [COL_W-1:0]             load_col,
   output rcc_pkg::pixel_type           load_pix,
   output rcc_pkg::tag_type             load_tag
);
   import rcc_pkg::*;

   localparam int EW = COL_W + 1;
   localparam int XW = (EW > WIDTH_W) ? EW : WIDTH_W;

   logic [COL_W-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]    in_row_ff, in_row_in;
   logic [HEIGHT_W-1:0] out_row_ff, out_row_in;
   logic [XW-1:0]       fw_x;
   logic [EW-1:0]       eff_w;
   logic [ROW_W-1:0]    eff_h;
   logic                wrap, pushing, ignore, emit, last_col, oc_last, or_last, fe, accept;
   logic [COL_W-1:0]    col0;
   logic [ROW_W-1:0]    row0;
   logic [2:0]          rv, cv;

   always_comb begin
      fw_x   = XW'(frame_width);
      eff_w  = (fw_x == '0) ? EW'(1) :
               (fw_x > XW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(fw_x);
      eff_h  = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);
      accept = req_valid && adv;

      wrap    = {1'b0, in_col_ff} >= eff_w;
      col0    = wrap ? '0 : in_col_ff;
      row0    = in_row_ff + ROW_W'(wrap);
      pushing = row0 < eff_h;
      ignore  = pushing && (req_op == OP_DRAIN);
      emit    = (row0 >= ROW_W'(2)) || ((row0 == ROW_W'(1)) && (col0 != '0));
      last_col = ({1'b0, col0} + EW'(1)) >= eff_w;
      oc_last  = ({1'b0, out_col_ff} + EW'(1)) >= eff_w;
      or_last  = ({1'b0, out_row_ff} + ROW_W'(1)) >= eff_h;
      fe       = oc_last && or_last;

      rv = {!or_last, {1'b0, out_row_ff} < eff_h,
            (out_row_ff != '0) && ({1'b0, out_row_ff} <= eff_h)};
      cv = {!oc_last, {1'b0, out_col_ff} < eff_w,
            (out_col_ff != '0) && ({1'b0, out_col_ff} <= eff_w)};

      load     = accept && !ignore;
      load_col = col0;
      load_pix = pushing ? req_pix : '0;
      for (int i = 0; i < TAPS; i++) begin
         load_tag.mask[i] = rv[i / 3] && cv[i % 3];
      end
      load_tag.emit      = emit;
      load_tag.frame_end = emit && fe;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (ignore) begin
            in_col_in = col0;
            in_row_in = row0;
         end else if (emit && fe) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (last_col) begin
               in_col_in = '0;
               in_row_in = row0 + ROW_W'(1);
            end else begin
               in_col_in = col0 + COL_W'(1);
               in_row_in = row0;
            end
            if (emit) begin
               if (oc_last) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + HEIGHT_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

[rtl/core/rcc_window.sv]
// line store memory with write forwarding and the 3x3 window shift
// depends on rcc_pkg
module rcc_window #(
   parameter int MAX_WIDTH = rcc_pkg::MAX_WIDTH_DEF,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               load,
   input  logic [COL_W-1:0]   load_col,
   input  rcc_pkg::pixel_type load_pix,
   input  rcc_pkg::tag_type   load_tag,
   output logic               win_valid,
   output rcc_pkg::pixel_type win [rcc_pkg::TAPS],
   output rcc_pkg::tag_type   win_tag
);
   import rcc_pkg::*;

   logic [47:0]      mem [MAX_WIDTH];
   logic [47:0]      q_ff, fwd_data_ff, ent, wr_data;
   logic             fwd_ff, s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   pixel_type        s1_pix_ff;
   tag_type          s1_tag_ff;
   pixel_type        win_ff [TAPS];
   pixel_type        above, above2;

   always_comb begin
      ent     = fwd_ff ? fwd_data_ff : q_ff;
      above   = ent[23:0];
      above2  = ent[47:24];
      wr_data = {above, s1_pix_ff};
      for (int r = 0; r < 3; r++) begin
         win[r * 3]     = win_ff[r * 3 + 1];
         win[r * 3 + 1] = win_ff[r * 3 + 2];
      end
      win[2]    = above2;
      win[5]    = above;
      win[8]    = s1_pix_ff;
      win_tag   = s1_tag_ff;
      win_valid = s1_valid_ff && s1_tag_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= mem[load_col];
      end
      if (adv && s1_valid_ff) begin
         mem[s1_col_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fwd_data_ff <= wr_data;
         s1_col_ff   <= load_col;
         s1_pix_ff   <= load_pix;
         s1_tag_ff   <= load_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         for (int i = 0; i < TAPS; i++) win_ff[i] <= '0;
      end else if (adv) begin
         s1_valid_ff <= load;
         if (load) begin
            fwd_ff <= s1_valid_ff && (s1_col_ff == load_col);
         end
         if (s1_valid_ff) begin
            for (int i = 0; i < TAPS; i++) begin
               win_ff[i] <= s1_tag_ff.frame_end ? '0 : win[i];
            end
         end
      end
   end

endmodule

[rtl/core/rcc_conv.sv]
// nine-stage tap pipeline: one multiply-add and truncation per tap, then clamp
// depends on rcc_pkg
module rcc_conv #(
   parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  rcc_pkg::pixel_type            in_win [rcc_pkg::TAPS],
   input  rcc_pkg::tag_type              in_tag,
   input  logic [2:0][rcc_pkg::CSR_W-1:0] coef,
   output logic                          out_valid,
   output rcc_pkg::result_type           out_result
);
   import rcc_pkg::*;

   localparam int F     = COEF_FRAC_BITS;
   localparam int SUM_W = 28 - F;
   localparam int TW    = SUM_W + F + 1;

   logic                    v_ff   [TAPS];
   logic signed [SUM_W-1:0] sum_ff [TAPS][3];
   pixel_type               win_ff [TAPS][TAPS];
   tag_type                 tag_ff [TAPS];

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      logic                    sv;
      logic signed [SUM_W-1:0] ss [3];
      logic signed [SUM_W-1:0] sn [3];
      pixel_type               sw [TAPS];
      tag_type                 st;
      logic signed [15:0]      c;
      logic signed [TW-1:0]    t, bias;

      if (k == 0) begin : g_first
         always_comb begin
            sv = in_valid;
            st = in_tag;
            for (int i = 0; i < TAPS; i++) sw[i] = in_win[i];
            for (int ch = 0; ch < 3; ch++) ss[ch] = '0;
         end
      end else begin : g_next
         always_comb begin
            sv = v_ff[k - 1];
            st = tag_ff[k - 1];
            for (int i = 0; i < TAPS; i++) sw[i] = win_ff[k - 1][i];
            for (int ch = 0; ch < 3; ch++) ss[ch] = sum_ff[k - 1][ch];
         end
      end

      always_comb begin
         c = $signed(coef[k / 3][16 * (k % 3) +: 16]);
         t = '0;
         bias = '0;
         for (int ch = 0; ch < 3; ch++) begin
            t = (TW'(ss[ch]) <<< F)
              + (TW'($signed({1'b0, sw[k][16 - 8 * ch +: 8]})) * TW'(c));
            bias = t[TW-1] ? TW'((1 << F) - 1) : '0;
            sn[ch] = st.mask[k] ? SUM_W'((t + bias) >>> F) : ss[ch];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= sv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k] <= st;
            for (int i = 0; i < TAPS; i++) win_ff[k][i] <= sw[i];
            for (int ch = 0; ch < 3; ch++) sum_ff[k][ch] <= sn[ch];
         end
      end
   end

   function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > SUM_W'(PIX_MAX)) r = 8'(PIX_MAX);
      else r = v[7:0];
      return r;
   endfunction

   always_comb begin
      out_valid            = v_ff[TAPS-1];
      out_result.red_out   = clamp8(sum_ff[TAPS-1][0]);
      out_result.green_out = clamp8(sum_ff[TAPS-1][1]);
      out_result.blue_out  = clamp8(sum_ff[TAPS-1][2]);
      out_result.frame_end = tag_ff[TAPS-1].frame_end;
   end

endmodule

[rtl/core/rcc_outq.sv]
// two-word result buffer; holds the pipeline when full
// depends on rcc_pkg
module rcc_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcc_pkg::result_type push_result,
   input  logic                pop,
   output logic                room,
   output logic                head_valid,
   output rcc_pkg::result_type head
);
   import rcc_pkg::*;

   result_type buf_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   always_comb begin
      room       = cnt_ff != 2'd2;
      head_valid = cnt_ff != 2'd0;
      head       = buf_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= push_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[rtl/core/rgb_conv3x3_clamp_top.sv]
// top level of the streaming rgb 3x3 convolution with clamp
// depends on rcc_pkg, rcc_if, rcc_front, rcc_window, rcc_conv, rcc_outq
// Takes one word and gives one result per clock at full rate while the result buffer has
// room. A word goes through the position logic, a read of the line store (one memory of
// MAX_WIDTH entries, each holding the pixels of the two previous rows at that column), the
// window shift and a nine-stage tap pipeline; results lag by the one row and one pixel
// inherent to the window. A two-word result buffer lets input continue while a result
// waits; the pipeline holds only when that buffer is full. The line store needs no clearing
// after reset. The user must write configuration only while idle; nothing enforces it.
module rgb_conv3x3_clamp_top #(
   parameter int MAX_WIDTH      = rcc_pkg::MAX_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   rcc_req_if.sink                       req_ch,
   rcc_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [rcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcc_pkg::CSR_W-1:0]     csr_write_data
);
   import rcc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [WIDTH_W-1:0]    frame_width_ff;
   logic [HEIGHT_W-1:0]   frame_height_ff;
   logic [2:0][CSR_W-1:0] coef_ff;

   logic             adv, load, win_valid, conv_valid;
   logic [COL_W-1:0] load_col;
   pixel_type        load_pix;
   tag_type          load_tag, win_tag;
   pixel_type        win [TAPS];
   result_type       conv_result, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         coef_ff[0]      <= COEF_TOP_RST;
         coef_ff[1]      <= COEF_MID_RST;
         coef_ff[2]      <= COEF_BOTTOM_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[HEIGHT_W-1:0];
            CSR_COEF_TOP:     coef_ff[0]      <= csr_write_data;
            CSR_COEF_MID:     coef_ff[1]      <= csr_write_data;
            CSR_COEF_BOTTOM:  coef_ff[2]      <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = adv;

   rcc_front #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_ch.valid),
      .req_op       (req_ch.op),
      .req_pix      ({req_ch.red_in, req_ch.green_in, req_ch.blue_in}),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .load         (load),
      .load_col     (load_col),
      .load_pix     (load_pix),
      .load_tag     (load_tag)
   );

   rcc_window #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_window (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .load      (load),
      .load_col  (load_col),
      .load_pix  (load_pix),
      .load_tag  (load_tag),
      .win_valid (win_valid),
      .win       (win),
      .win_tag   (win_tag)
   );

   rcc_conv #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_conv (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (win_valid),
      .in_win     (win),
      .in_tag     (win_tag),
      .coef       (coef_ff),
      .out_valid  (conv_valid),
      .out_result (conv_result)
   );

   rcc_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (conv_valid && adv),
      .push_result (conv_result),
      .pop         (rsp_ch.valid && rsp_ch.ready),
      .room        (adv),
      .head_valid  (rsp_ch.valid),
      .head        (head)
   );

   assign rsp_ch.red_out   = head.red_out;
   assign rsp_ch.green_out = head.green_out;
   assign rsp_ch.blue_out  = head.blue_out;
   assign rsp_ch.frame_end = head.frame_end;

endmodule
